@@ sv/owm_pkg.sv @@
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-Wire bus master
// Command codes, queue geometry, register map and the item/result records.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int TICK_W        = 10;
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_W     = 3;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int BIT_IDX_W     = 3;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = 2;
    localparam int QUEUE_CNT_W   = 3;

    // command codes carried on the input tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // register map
    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_RECOVER  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_START    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WRITE_HOLD     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_READ_START     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_READ_REST      = 3'd7;

    function automatic logic [TICK_W-1:0] reg_reset_value(input logic [REG_IDX_W-1:0] idx);
        logic [TICK_W-1:0] val;
        case (idx)
            REG_RESET_LOW:     val = 10'd500;
            REG_PRESENCE_WAIT: val = 10'd70;
            REG_RESET_RECOVER: val = 10'd500;
            REG_WRITE_START:   val = 10'd10;
            REG_WRITE_HOLD:    val = 10'd50;
            REG_READ_START:    val = 10'd5;
            REG_READ_SAMPLE:   val = 10'd5;
            REG_READ_REST:     val = 10'd50;
            default:           val = 10'd1;
        endcase
        return val;
    endfunction

    // one classified tick request
    typedef struct packed {
        logic                     start;      // op asks for a command
        logic [1:0]               op;
        logic [BITS_PER_BYTE-1:0] write_data;
        logic                     line_level;
    } item_t;

    // one result
    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] read_data;
        logic                     device_present;
        logic                     done_res;
        logic                     busy_res;
        logic                     line_release;
    } result_t;

endpackage

@@ sv/one_wire_bus_master.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master: 1-Wire bus master sequencer
// Reset with presence detect, byte write and byte read, timed in ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request on the s_ channel for every microsecond tick. tuser
//   carries the op (tick only, reset, write byte, read byte); an op other
//   than tick only starts a command when the sequencer is idle and is
//   ignored while busy. tdata carries the byte to write and the sampled
//   bus level for that tick.
//   Every request yields exactly one result on the m_ channel: the line
//   drive to apply, busy, a one-tick done pulse, the presence flag and the
//   last byte read.
//   Timing registers are written over the cfg_ channel, index 0..7, low
//   10 bits kept; cfg_ready is always high. Write them only while idle.
//   Throughput: one request per cycle while m_tready keeps the output
//   register free. Path: a taken request is written into the queue,
//   popped from it into the output register, and its result is then
//   valid on the m_ channel until it is taken.
//   Reset: timing registers return to their defaults, the queue empties,
//   the sequencer goes idle with the line released.
//   Stall: while m_tready is low the result holds; requests keep entering
//   the four-entry queue until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_data, [8] line_level, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] line_release, [1] busy_res, [2] done_res,
                                   // [3] device_present, [11:4] read_data, [15:12] zero
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    owm_pkg::item_t   push_item;
    owm_pkg::item_t   head_item;
    owm_pkg::result_t result;
    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_empty;

    // classify requests and feed the queue
    owm_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // decouple intake from the sequencer so each side can stall alone
    owm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // step the slot phases, one tick per popped request
    owm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .head_item   (head_item),
        .queue_empty (queue_empty),
        .pop         (pop),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (result)
    );

    // pack the result, lowest field first
    assign m_tdata = {4'b0000, result.read_data, result.device_present,
                      result.done_res, result.busy_res, result.line_release};

endmodule

@@ sv/owm_front.sv @@
// ----------------------------------------------------------------------------
// owm_front: input side of the 1-Wire bus master
// Unpacks each incoming tick request, classifies its op and pushes it into
// the request queue.
// ----------------------------------------------------------------------------
module owm_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 queue_full,
    output logic                 push,
    output owm_pkg::item_t       push_item
);

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        push_item.op         = s_tuser;
        push_item.start      = (s_tuser != owm_pkg::OP_TICK);
        push_item.write_data = s_tdata[7:0];
        push_item.line_level = s_tdata[8];
    end

endmodule

@@ sv/owm_queue.sv @@
// ----------------------------------------------------------------------------
// owm_queue: short request queue
// Decouples request intake from the bus sequencer.
// ----------------------------------------------------------------------------
module owm_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  owm_pkg::item_t       push_item,
    input  logic                 pop,
    output owm_pkg::item_t       head_item,
    output logic                 full,
    output logic                 empty
);

    owm_pkg::item_t                    mem [owm_pkg::QUEUE_DEPTH];
    logic [owm_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [owm_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [owm_pkg::QUEUE_CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == owm_pkg::QUEUE_CNT_W'(owm_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/owm_seq.sv @@
// ----------------------------------------------------------------------------
// owm_seq: bus sequencer of the 1-Wire bus master
// Holds the timing registers, steps the slot phases once per tick request
// and keeps the result in an output register.
// ----------------------------------------------------------------------------
module owm_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [owm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [owm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  owm_pkg::item_t                      head_item,
    input  logic                                queue_empty,
    output logic                                pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output owm_pkg::result_t                    m_result
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_REC  = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_HOLD  = 4'd5;
    localparam logic [3:0] PH_RD_LOW   = 4'd6;
    localparam logic [3:0] PH_RD_WAIT  = 4'd7;
    localparam logic [3:0] PH_RD_REST  = 4'd8;

    localparam int TW = owm_pkg::TICK_W;
    localparam int BW = owm_pkg::BITS_PER_BYTE;
    localparam logic [owm_pkg::BIT_IDX_W-1:0] LAST_BIT =
        owm_pkg::BIT_IDX_W'(owm_pkg::BITS_PER_BYTE - 1);

    logic [TW-1:0]                     cfg_reg [owm_pkg::NUM_REGS];

    logic [3:0]                        phase_reg, phase_next;
    logic [TW-1:0]                     tick_reg, tick_next;
    logic [owm_pkg::BIT_IDX_W-1:0]     bit_reg, bit_next;
    logic [BW-1:0]                     shift_reg, shift_next;
    logic [BW-1:0]                     rbyte_reg, rbyte_next;
    logic                              present_reg, present_next;
    logic                              drive_reg, drive_next;
    logic                              out_valid_reg;
    owm_pkg::result_t                  out_reg;

    logic                              enter_en;
    logic [3:0]                        enter_ph;
    logic                              done;
    logic [TW-1:0]                     tick_inc;
    logic [TW-1:0]                     len;
    logic [3:0]                        len_idx;
    logic                              expire;
    logic                              last;

    assign cfg_ready = 1'b1;
    assign pop       = !queue_empty && (!out_valid_reg || m_ready);
    assign m_valid   = out_valid_reg;
    assign m_result  = out_reg;

    assign tick_inc = tick_reg + 1'b1;
    assign len_idx  = phase_reg - 4'd1;
    assign len      = (phase_reg >= PH_RST_LOW && phase_reg <= PH_RD_REST)
                      ? cfg_reg[len_idx[owm_pkg::REG_IDX_W-1:0]] : TW'(1);
    assign expire   = (tick_inc >= len) || (tick_inc == '0);
    assign last     = (bit_reg == LAST_BIT);

    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        rbyte_next   = rbyte_reg;
        present_next = present_reg;
        drive_next   = drive_reg;
        enter_en     = 1'b0;
        enter_ph     = PH_IDLE;
        done         = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (head_item.start) begin
                bit_next = '0;
                enter_en = 1'b1;
                case (head_item.op)
                    owm_pkg::OP_RESET: begin
                        enter_ph = PH_RST_LOW;
                    end
                    owm_pkg::OP_WRITE: begin
                        shift_next = head_item.write_data;
                        enter_ph   = PH_WR_LOW;
                    end
                    default: begin
                        shift_next = '0;
                        enter_ph   = PH_RD_LOW;
                    end
                endcase
            end
        end else begin
            tick_next = tick_inc;
            if (expire) begin
                enter_en = 1'b1;
                case (phase_reg)
                    PH_RST_LOW: begin
                        enter_ph = PH_RST_WAIT;
                    end
                    PH_RST_WAIT: begin
                        present_next = !head_item.line_level;
                        enter_ph     = PH_RST_REC;
                    end
                    PH_WR_LOW: begin
                        enter_ph = PH_WR_HOLD;
                    end
                    PH_RD_LOW: begin
                        enter_ph = PH_RD_WAIT;
                    end
                    PH_RD_WAIT: begin
                        if (head_item.line_level) begin
                            shift_next = shift_reg | (BW'(1) << bit_reg);
                        end
                        enter_ph = PH_RD_REST;
                    end
                    PH_WR_HOLD, PH_RD_REST: begin
                        if (!last) begin
                            bit_next = bit_reg + 1'b1;
                            enter_ph = (phase_reg == PH_WR_HOLD) ? PH_WR_LOW : PH_RD_LOW;
                        end else begin
                            if (phase_reg == PH_RD_REST) begin
                                rbyte_next = shift_reg;
                            end
                            bit_next = '0;
                            done     = 1'b1;
                            enter_ph = PH_IDLE;
                        end
                    end
                    default: begin
                        done     = 1'b1;
                        enter_ph = PH_IDLE;
                    end
                endcase
            end
        end

        if (enter_en) begin
            phase_next = enter_ph;
            tick_next  = '0;
            case (enter_ph)
                PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive_next = 1'b0;
                PH_WR_HOLD:                       drive_next = shift_next[bit_next];
                default:                          drive_next = 1'b1;
            endcase
        end
    end

    // timing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < owm_pkg::NUM_REGS; i++) begin
                cfg_reg[i] <= owm_pkg::reg_reset_value(owm_pkg::REG_IDX_W'(i));
            end
        end else if (cfg_valid && cfg_ready &&
                     cfg_index < owm_pkg::CFG_IDX_W'(owm_pkg::NUM_REGS)) begin
            cfg_reg[cfg_index[owm_pkg::REG_IDX_W-1:0]] <= cfg_data[TW-1:0];
        end
    end

    // sequencer state, advanced once per popped request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            rbyte_reg   <= '0;
            present_reg <= 1'b0;
            drive_reg   <= 1'b1;
        end else if (pop) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            rbyte_reg   <= rbyte_next;
            present_reg <= present_next;
            drive_reg   <= drive_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg.line_release   <= drive_next;
            out_reg.busy_res       <= (phase_next != PH_IDLE);
            out_reg.done_res       <= done;
            out_reg.device_present <= present_next;
            out_reg.read_data      <= rbyte_next;
        end
    end

endmodule

@@ sv/owm_checker.sv @@
// ----------------------------------------------------------------------------
// owm_checker: port-level checks of the 1-Wire bus master
// Watches the result channel for sequencing and handshake slips.
// ----------------------------------------------------------------------------
module owm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // a finishing tick is already idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1])
        else $error("done asserted while still busy");

    // an idle sequencer never drives the line
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[0])
        else $error("line driven low while idle");

    // done lasts one result only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[2] ##1 m_tvalid |-> !m_tdata[2])
        else $error("done held over two results");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (.*);
